FILE: sv/ppd_pkg.sv
// Shared types and constants for the PPM pulse train decoder.
// No dependencies; imported by every module of the block.

package ppd_pkg;

	localparam int unsigned CHANNEL_COUNT = 8;

	localparam int unsigned CAP_W  = 16;
	localparam int unsigned REG_W  = 14;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned SYNC_W = 8;

	// Register indexes on the configuration channel
	localparam logic [IDX_W-1:0] REG_SYNC_TH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GLITCH_TH = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTRE    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLAMP_HI  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLAMP_LO  = 3'd4;

	// Register reset values in timer ticks
	localparam logic [REG_W-1:0] RST_SYNC_TH   = 14'd3180;
	localparam logic [REG_W-1:0] RST_GLITCH_TH = 14'd968;
	localparam logic [REG_W-1:0] RST_CENTRE    = 14'd2074;
	localparam logic [REG_W-1:0] RST_CLAMP_HI  = 14'd2834;
	localparam logic [REG_W-1:0] RST_CLAMP_LO  = 14'd1313;

	typedef enum logic [2:0] {
		KIND_SYNC     = 3'd0,
		KIND_GLITCH   = 3'd1,
		KIND_CHANNEL  = 3'd2,
		KIND_WAIT     = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef struct packed {
		logic [REG_W-1:0] sync_th;
		logic [REG_W-1:0] glitch_th;
		logic [REG_W-1:0] centre;
		logic [REG_W-1:0] clamp_hi;
		logic [REG_W-1:0] clamp_lo;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [CAP_W-1:0]    value;
		logic [SYNC_W-1:0]   sync_total;
	} result_t;

endpackage

FILE: sv/ppd_cfg_regs.sv
// Configuration register file of the PPM pulse train decoder.
// Depends on ppd_pkg for register indexes, reset values and cfg_t.

module ppd_cfg_regs
	import ppd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_th   <= RST_SYNC_TH;
			cfg_q.glitch_th <= RST_GLITCH_TH;
			cfg_q.centre    <= RST_CENTRE;
			cfg_q.clamp_hi  <= RST_CLAMP_HI;
			cfg_q.clamp_lo  <= RST_CLAMP_LO;
		end else if (wr_en) begin
			// drop writes to unused indexes
			unique case (wr_index)
				REG_SYNC_TH:   cfg_q.sync_th   <= wr_data;
				REG_GLITCH_TH: cfg_q.glitch_th <= wr_data;
				REG_CENTRE:    cfg_q.centre    <= wr_data;
				REG_CLAMP_HI:  cfg_q.clamp_hi  <= wr_data;
				REG_CLAMP_LO:  cfg_q.clamp_lo  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/ppd_decode.sv
// Interval classifier and decoder state of the PPM pulse train decoder.
// Depends on ppd_pkg for cfg_t, result_t and kind_t.

module ppd_decode
	import ppd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [CAP_W-1:0] capture,
	input  cfg_t             cfg,
	output result_t          result
);

	logic [CAP_W-1:0]  prev_capture_q;
	logic [CNT_W-1:0]  chan_cnt_q;
	logic              resync_q;
	logic [SYNC_W-1:0] sync_cnt_q;

	logic [CAP_W-1:0]  interval;
	logic [REG_W-1:0]  clamped;
	logic [CAP_W-1:0]  diff;
	logic [CNT_W-1:0]  chan_cnt_d;
	logic              resync_d;
	logic [SYNC_W-1:0] sync_cnt_d;

	assign interval = capture - prev_capture_q;

	// clamp_hi is tested before clamp_lo; the result always fits a register
	always_comb begin
		if (interval > {2'b00, cfg.clamp_hi}) begin
			clamped = cfg.clamp_hi;
		end else if (interval < {2'b00, cfg.clamp_lo}) begin
			clamped = cfg.clamp_lo;
		end else begin
			clamped = interval[REG_W-1:0];
		end
	end

	assign diff = {2'b00, clamped} - {2'b00, cfg.centre};

	always_comb begin
		chan_cnt_d        = chan_cnt_q;
		resync_d          = resync_q;
		sync_cnt_d        = sync_cnt_q;
		result.kind       = KIND_GLITCH;
		result.slot       = '0;
		result.value      = '0;
		if (interval > {2'b00, cfg.sync_th}) begin
			resync_d    = 1'b0;
			sync_cnt_d  = sync_cnt_q + 1'b1;
			chan_cnt_d  = '0;
			result.kind = KIND_SYNC;
		end else if (interval < {2'b00, cfg.glitch_th}) begin
			result.kind = KIND_GLITCH;
		end else if (resync_q) begin
			result.kind = KIND_WAIT;
		end else if (chan_cnt_q < CNT_W'(CHANNEL_COUNT)) begin
			result.kind  = KIND_CHANNEL;
			result.slot  = chan_cnt_q[SLOT_W-1:0];
			result.value = {diff[CAP_W-2:0], 1'b0};
			chan_cnt_d   = chan_cnt_q + 1'b1;
		end else begin
			resync_d    = 1'b1;
			result.kind = KIND_OVERFLOW;
		end
		result.sync_total = sync_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_capture_q <= '0;
			chan_cnt_q     <= '0;
			resync_q       <= 1'b1;
			sync_cnt_q     <= '0;
		end else if (advance) begin
			prev_capture_q <= capture;
			chan_cnt_q     <= chan_cnt_d;
			resync_q       <= resync_d;
			sync_cnt_q     <= sync_cnt_d;
		end
	end

endmodule

FILE: sv/ppm_pulse_train_decoder_core.sv
// Top level of the PPM pulse train decoder: input register, decode, result register.
// Depends on ppd_pkg, ppd_cfg_regs and ppd_decode.
//
// Usage:
//   Input channel: one 16-bit timer capture word per pulse edge on capture_time,
//   taken when in_valid is high and in_stall is low.
//   Output channel: one result word per capture (event_kind, channel_index,
//   channel_value, sync_total), taken when out_valid is high and out_stall low.
//   Configuration channel: cfg_ready is always high; a write lands when cfg_valid
//   is high. cfg_index selects the register (0 sync threshold, 1 glitch
//   threshold, 2 centre, 3 clamp high, 4 clamp low); other indexes are dropped.
//   Write only while no capture is in flight.
// Pipeline:
//   A capture passes from the input register through decode to the result register;
//   one per cycle is sustained while out_stall is low, since a 16-bit subtract, the
//   threshold compares, the clamp and the centre subtract sit between the input and
//   result registers, and the decoder state updates as each word passes through.
// Reset:
//   arst_n clears both pipeline stages, restores the register defaults and puts
//   the decoder in the waiting-for-sync state with a previous capture of zero.
// Stall:
//   While out_stall holds a result, the input register still fills once; after
//   that in_stall rises and the pipeline holds.

module ppm_pulse_train_decoder_core
	import ppd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// capture input
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CAP_W-1:0]         capture_time,
	// result output
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               event_kind,
	output logic [SLOT_W-1:0]        channel_index,
	output logic signed [CAP_W-1:0]  channel_value,
	output logic [SYNC_W-1:0]        sync_total,
	// configuration writes
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [REG_W-1:0]         cfg_data
);

	cfg_t             cfg;
	result_t          result;

	logic             valid_s1;
	logic [CAP_W-1:0] capture_s1;
	logic             valid_s2;
	result_t          result_s2;

	logic             advance_s2;
	logic             advance_s1;

	// Registers take every write; writes must only come while idle (not enforced here)
	assign cfg_ready = 1'b1;

	ppd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Result register loads when empty or when its word is being taken
	assign advance_s2 = !valid_s2 || !out_stall;
	// Decode consumes the input-register word when the result register can load
	assign advance_s1 = valid_s1 && advance_s2;
	// Hold off the sender only when the input register is full and cannot drain
	assign in_stall   = valid_s1 && !advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			capture_s1 <= capture_time;
		end
	end

	// Decoder state advances exactly once per word leaving the input register
	ppd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance_s1),
		.capture (capture_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign event_kind    = result_s2.kind;
	assign channel_index = result_s2.slot;
	assign channel_value = result_s2.value;
	assign sync_total    = result_s2.sync_total;

endmodule

FILE: sv/ppd_checker.sv
// Port-level checker for the PPM pulse train decoder, bound to the top level.
// Depends on ppd_pkg for kind codes and the channel count.

module ppd_checker
	import ppd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [2:0]               event_kind,
	input logic [SLOT_W-1:0]        channel_index,
	input logic signed [CAP_W-1:0]  channel_value,
	input logic [SYNC_W-1:0]        sync_total
);

	// A held result word keeps all its fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind)
			&& $stable(channel_index) && $stable(channel_value) && $stable(sync_total))
		else $error("held result word changed");

	// Back-pressure on the input only comes from a blocked output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output can drain");

	// Non-channel events carry zero slot and value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != KIND_CHANNEL |-> channel_index == '0 && channel_value == '0)
		else $error("slot or value set on non-channel event");

	// Channel words use a slot in range and a doubled (even) value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == KIND_CHANNEL
			|-> {1'b0, channel_index} < (SLOT_W + 1)'(CHANNEL_COUNT) && !channel_value[0])
		else $error("bad channel slot or odd channel value");

	// Sync total moves only on a sync word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != KIND_SYNC && !out_stall
			##1 out_valid && event_kind != KIND_SYNC |-> $stable(sync_total))
		else $error("sync total changed without a sync");

endmodule

bind ppm_pulse_train_decoder_core ppd_checker u_ppd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.event_kind    (event_kind),
	.channel_index (channel_index),
	.channel_value (channel_value),
	.sync_total    (sync_total)
);
